FILE: hw/rtl/kmp_wildcard_byte_search_macros.svh
// assertion macros for the wildcard byte search block
`ifndef KMP_WILDCARD_BYTE_SEARCH_MACROS_SVH
`define KMP_WILDCARD_BYTE_SEARCH_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KMPW_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KMPW_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kmpw_pkg.sv
// shared types and constants for the wildcard byte search block
package kmpw_pkg;

    localparam int OFF_W = 32;
    localparam logic [7:0] WC_BYTE_RESET = 8'd63;

    localparam logic REG_WC_EN   = 1'b0;
    localparam logic REG_WC_BYTE = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef enum logic {
        MODE_BUILD,
        MODE_TEXT
    } t_mode;

    typedef struct packed {
        logic       wc_en;
        logic [7:0] wc_byte;
    } t_cfg;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } t_result;

endpackage

FILE: hw/rtl/kmpw_cmp.sv
// shared byte compare unit with wildcard handling
module kmpw_cmp (
    input  kmpw_pkg::t_mode i_mode,
    input  kmpw_pkg::t_cfg  i_cfg,
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_pat,
    output logic            o_agree
);

    logic wild_p;
    logic wild_c;

    assign wild_p  = i_cfg.wc_en && (i_pat == i_cfg.wc_byte);
    // incoming pattern byte may be the wildcard only while building the table
    assign wild_c  = i_cfg.wc_en && (i_byte == i_cfg.wc_byte)
                     && (i_mode == kmpw_pkg::MODE_BUILD);
    assign o_agree = (i_pat == i_byte) || wild_p || wild_c;

endmodule

FILE: hw/rtl/kmpw_core.sv
// sequencer, pattern and failure memories, text state and result register
`include "kmp_wildcard_byte_search_macros.svh"

module kmpw_core #(
    parameter int MAX_PATTERN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmpw_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  kmpw_pkg::t_op     i_op,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_out_ready,
    output kmpw_pkg::t_result o_result
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] LMAX = LW'(MAX_PATTERN);
    localparam logic [LW-1:0] LONE = LW'(1);

    logic [7:0]    pat_mem  [MAX_PATTERN];
    logic [AW-1:0] fail_mem [MAX_PATTERN];

    kmpw_pkg::t_state  r_state, n_state;
    kmpw_pkg::t_mode   r_mode, n_mode;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic [LW-1:0]     r_j, n_j;
    logic [LW-1:0]     r_plen, n_plen;
    logic [LW-1:0]     r_bpl, n_bpl;
    logic [LW-1:0]     r_mc, n_mc;
    logic [kmpw_pkg::OFF_W-1:0] r_toff, n_toff;
    logic              r_done, n_done;
    kmpw_pkg::t_result r_pend, n_pend;
    kmpw_pkg::t_result r_out, n_out;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_pat_q;
    logic [AW-1:0]     r_fail_q;

    logic          acc;
    logic          go_chain;
    logic          go_emit;
    logic          agree;
    logic          step;
    logic [LW-1:0] jn;
    logic [LW-1:0] jm1;
    logic          hit;
    logic          cmp_emit;
    logic          out_free;
    logic          pat_we;
    logic [AW-1:0] pat_waddr;
    logic          fail_we;
    logic [AW-1:0] fail_waddr;
    logic [AW-1:0] fail_wdata;

    kmpw_cmp u_cmp (
        .i_mode  (r_mode),
        .i_cfg   (i_cfg),
        .i_byte  (r_byte),
        .i_pat   (r_pat_q),
        .o_agree (agree)
    );

    // decode of the current step
    always_comb begin
        acc      = i_valid && (r_state == kmpw_pkg::ST_IDLE);
        go_chain = 1'b0;
        go_emit  = 1'b0;
        if (i_op == kmpw_pkg::OP_APPEND) begin
            go_chain = (r_plen != LMAX) && (r_plen != '0);
        end else if (i_op == kmpw_pkg::OP_TEXT) begin
            go_chain = !r_done && (r_plen != '0);
            go_emit  = !r_done && (r_plen == '0);
        end
        step     = !agree && (r_j != '0);
        jn       = agree ? (r_j + LONE) : r_j;
        jm1      = r_j - LONE;
        hit      = (jn >= r_plen);
        cmp_emit = (r_mode == kmpw_pkg::MODE_TEXT) && !step && (hit || r_last);
        out_free = !r_ovalid || i_out_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmpw_pkg::ST_IDLE: begin
                if (acc && go_chain) begin
                    n_state = kmpw_pkg::ST_RD;
                end else if (acc && go_emit) begin
                    n_state = kmpw_pkg::ST_FIN;
                end
            end
            kmpw_pkg::ST_RD: begin
                n_state = kmpw_pkg::ST_CMP;
            end
            kmpw_pkg::ST_CMP: begin
                if (step) begin
                    n_state = kmpw_pkg::ST_RD;
                end else if (cmp_emit) begin
                    n_state = kmpw_pkg::ST_FIN;
                end else begin
                    n_state = kmpw_pkg::ST_IDLE;
                end
            end
            kmpw_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = kmpw_pkg::ST_IDLE;
                end
            end
            default: n_state = kmpw_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_ready    = (r_state == kmpw_pkg::ST_IDLE);
        n_mode     = r_mode;
        n_byte     = r_byte;
        n_last     = r_last;
        n_j        = r_j;
        n_plen     = r_plen;
        n_bpl      = r_bpl;
        n_mc       = r_mc;
        n_toff     = r_toff;
        n_done     = r_done;
        n_pend     = r_pend;
        n_out      = r_out;
        n_ovalid   = r_ovalid && !i_out_ready;
        pat_we     = 1'b0;
        pat_waddr  = r_plen[AW-1:0];
        fail_we    = 1'b0;
        fail_waddr = r_plen[AW-1:0];
        fail_wdata = jn[AW-1:0];
        unique case (r_state)
            kmpw_pkg::ST_IDLE: begin
                if (acc) begin
                    n_byte = i_byte;
                    n_last = i_last;
                    unique case (i_op)
                        kmpw_pkg::OP_CLEAR: begin
                            n_plen = '0;
                            n_bpl  = '0;
                            n_mc   = '0;
                            n_toff = '0;
                            n_done = 1'b0;
                        end
                        kmpw_pkg::OP_APPEND: begin
                            n_mc   = '0;
                            n_toff = '0;
                            n_done = 1'b0;
                            if (r_plen != LMAX) begin
                                pat_we = 1'b1;
                                if (r_plen == '0) begin
                                    fail_we    = 1'b1;
                                    fail_waddr = '0;
                                    fail_wdata = '0;
                                    n_plen     = LONE;
                                    n_bpl      = '0;
                                end else begin
                                    n_j    = r_bpl;
                                    n_mode = kmpw_pkg::MODE_BUILD;
                                end
                            end
                        end
                        kmpw_pkg::OP_TEXT: begin
                            if (r_done) begin
                                if (i_last) begin
                                    n_mc   = '0;
                                    n_toff = '0;
                                    n_done = 1'b0;
                                end
                            end else if (r_plen == '0) begin
                                n_pend.found  = 1'b1;
                                n_pend.offset = '0;
                                n_done        = !i_last;
                                if (i_last) begin
                                    n_mc   = '0;
                                    n_toff = '0;
                                end
                            end else begin
                                n_j    = r_mc;
                                n_mode = kmpw_pkg::MODE_TEXT;
                            end
                        end
                        kmpw_pkg::OP_RSVD: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kmpw_pkg::ST_RD: begin
            end
            kmpw_pkg::ST_CMP: begin
                if (step) begin
                    n_j = LW'(r_fail_q);
                end else if (r_mode == kmpw_pkg::MODE_BUILD) begin
                    fail_we = 1'b1;
                    n_bpl   = jn;
                    n_plen  = r_plen + LONE;
                end else if (hit) begin
                    n_pend.found  = 1'b1;
                    n_pend.offset = r_toff - (kmpw_pkg::OFF_W'(r_plen) - 32'd1);
                    n_done        = !r_last;
                    n_mc          = '0;
                    if (r_last) begin
                        n_toff = '0;
                    end
                end else if (r_last) begin
                    n_pend.found  = 1'b0;
                    n_pend.offset = '0;
                    n_mc          = '0;
                    n_toff        = '0;
                    n_done        = 1'b0;
                end else begin
                    n_mc   = jn;
                    n_toff = r_toff + 32'd1;
                end
            end
            kmpw_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_valid  = r_ovalid;
        o_result = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kmpw_pkg::ST_IDLE;
            r_plen   <= '0;
            r_bpl    <= '0;
            r_mc     <= '0;
            r_toff   <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_plen   <= n_plen;
            r_bpl    <= n_bpl;
            r_mc     <= n_mc;
            r_toff   <= n_toff;
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_byte <= n_byte;
        r_last <= n_last;
        r_j    <= n_j;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // pattern and failure memories, registered reads
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= i_byte;
        end
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        r_pat_q  <= pat_mem[r_j[AW-1:0]];
        r_fail_q <= fail_mem[jm1[AW-1:0]];
    end

    `KMPW_ASSERT_IMP(a_j_in_pattern, i_clk, i_rst_n, r_state == kmpw_pkg::ST_CMP, r_j < r_plen, "compare index beyond pattern")
    `KMPW_ASSERT_IMP(a_plen_bound, i_clk, i_rst_n, r_plen != '0, (r_plen <= LMAX) && (r_bpl < r_plen), "pattern length or prefix out of range")
    `KMPW_ASSERT_NXT(a_fin_posts, i_clk, i_rst_n, r_state == kmpw_pkg::ST_FIN, r_ovalid, "result not posted after finish")

endmodule

FILE: hw/rtl/kmp_wildcard_byte_search.sv
// top level: stream ports, config registers and search core
// sequence: an append or text byte is taken in the idle state and holds the input for
// s >= 1 compare steps along the failure chain; each step is a memory read (ST_RD) plus one compare (ST_CMP)
// a word that yields a result also passes the finish state, which loads the output register and waits while it is full
// clear, reserved, ignored and first-byte-of-pattern words are handled in the idle state alone
// reset is synchronous: pattern length, text state and result valid clear, wildcard on with '?'
// pattern and failure memories are not cleared and need no clearing pass
module kmp_wildcard_byte_search #(
    parameter int MAX_PATTERN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic [1:0]  i_s_tuser,   // op
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // match_offset
    output logic [0:0]  o_m_tuser,   // found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              r_wc_en;
    logic [7:0]        r_wc_byte;
    logic              cfg_wr;
    logic              reg_sel;
    kmpw_pkg::t_cfg    cfg;
    kmpw_pkg::t_result result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc_en   <= 1'b1;
            r_wc_byte <= kmpw_pkg::WC_BYTE_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == kmpw_pkg::REG_WC_EN) begin
                r_wc_en <= pwdata[0];
            end else begin
                r_wc_byte <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'd0) begin
            if (reg_sel == kmpw_pkg::REG_WC_EN) begin
                prdata[0] = r_wc_en;
            end else begin
                prdata[7:0] = r_wc_byte;
            end
        end
    end

    assign cfg.wc_en   = r_wc_en;
    assign cfg.wc_byte = r_wc_byte;

    kmpw_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (kmpw_pkg::t_op'(i_s_tuser)),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_valid     (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_result    (result)
    );

    assign o_m_tdata    = result.offset;
    assign o_m_tuser[0] = result.found;

endmodule
